/* rtl/srrw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_pkg
// Shared types and constants for the selective-repeat receive window.
// ---------------------------------------------------------------------------
package srrw_pkg;
  localparam int WINDOW_DEF   = 256;
  localparam int ACK_BITS_DEF = 128;
  localparam int FORCE_COUNT  = 8;
  localparam logic [3:0]  ACK_EVERY_RST = 4'd2;
  localparam logic [15:0] IDLE_TICKS_RST = 16'd100;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ACK    = 1'b1;

  localparam logic [1:0] ST_IN_ORDER  = 2'd0;
  localparam logic [1:0] ST_OUT_ORDER = 2'd1;
  localparam logic [1:0] ST_DUP       = 2'd2;
  localparam logic [1:0] ST_BEYOND    = 2'd3;

  localparam logic REG_ACK_EVERY  = 1'b0;
  localparam logic REG_IDLE_TICKS = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MARK, S_WALK_RD, S_WALK, S_STATUS,
    S_ACK_RD, S_ACK_GATHER, S_ACK_OUT
  } state_t;

  typedef struct packed {
    logic [3:0]  ack_every;
    logic [15:0] idle_ack_ticks;
  } cfg_t;
endpackage
`default_nettype wire

/* rtl/srrw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_ram
// Generic simple dual-port (one write, one read) synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module srrw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/srrw_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_cfg
// APB-style configuration registers.
// ---------------------------------------------------------------------------
module srrw_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output      logic [31:0]  prdata,
  output      logic         pready,
  output      srrw_pkg::cfg_t cfg
);
  import srrw_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (paddr[2])
        REG_ACK_EVERY:  cfg_nxt.ack_every = pwdata[3:0];
        REG_IDLE_TICKS: cfg_nxt.idle_ack_ticks = pwdata[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACK_EVERY:  prdata = {28'd0, cfg_r.ack_every};
      REG_IDLE_TICKS: prdata = {16'd0, cfg_r.idle_ack_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{ack_every: ACK_EVERY_RST, idle_ack_ticks: IDLE_TICKS_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/srrw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srrw_ctrl
// Sequencer: marks, walks the base over the bitmap RAM, emits results.
// ---------------------------------------------------------------------------
module srrw_ctrl #(
  parameter int WINDOW   = srrw_pkg::WINDOW_DEF,
  parameter int ACK_BITS = srrw_pkg::ACK_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire srrw_pkg::cfg_t            cfg,
  input  wire logic                      start,
  input  wire logic                      in_op,
  input  wire logic [31:0]               in_seq,
  output      logic                      busy,
  output      logic                      mem_we,
  output      logic [$clog2(WINDOW)-1:0] mem_waddr,
  output      logic                      mem_wdata,
  output      logic [$clog2(WINDOW)-1:0] mem_raddr,
  input  wire logic                      mem_rdata,
  output      logic                      out_valid,
  output      logic                      out_kind,
  output      logic [1:0]                out_status,
  output      logic [8:0]                out_released,
  output      logic [31:0]               out_ack_base,
  output      logic [63:0]               out_bitmap_word,
  output      logic                      out_word_index,
  output      logic                      out_last
);
  import srrw_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int NB = (ACK_BITS < WINDOW) ? ACK_BITS : WINDOW;
  localparam int NW = (ACK_BITS + 63) / 64;
  localparam int RW = $clog2(WINDOW + 1);

  state_t       state_r, state_nxt;
  logic [31:0]  base_r, base_nxt;
  logic [31:0]  seq_r, seq_nxt;
  logic [3:0]   unack_r, unack_nxt;
  logic [15:0]  idle_r, idle_nxt;
  logic [1:0]   stat_r, stat_nxt;
  logic [RW-1:0] rel_r, rel_nxt;
  logic [AW:0]  cnt_r, cnt_nxt;
  logic [6:0]   bit_r, bit_nxt;
  logic [0:0]   widx_r, widx_nxt;
  logic [63:0]  word_r, word_nxt;
  logic         ack_r, ack_nxt;
  logic [31:0]  diff;
  logic [7:0]   bpos;
  logic [3:0]   force_val;

  assign diff = in_seq - base_r;
  assign bpos = {1'b0, widx_r, 6'd0} + {1'b0, bit_r};
  assign force_val = (cfg.ack_every > 4'(FORCE_COUNT)) ? cfg.ack_every : 4'(FORCE_COUNT);
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r; base_nxt = base_r; seq_nxt = seq_r;
    unack_nxt = unack_r; idle_nxt = idle_r; stat_nxt = stat_r;
    rel_nxt = rel_r; cnt_nxt = cnt_r; bit_nxt = bit_r; widx_nxt = widx_r;
    word_nxt = word_r; ack_nxt = ack_r;
    mem_we = 1'b0; mem_waddr = cnt_r[AW-1:0]; mem_wdata = 1'b0;
    mem_raddr = base_r[AW-1:0];
    out_valid = 1'b0; out_kind = KIND_STATUS; out_status = stat_r;
    out_released = 9'(rel_r); out_ack_base = base_r; out_bitmap_word = 64'd0;
    out_word_index = 1'b0; out_last = 1'b1;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(WINDOW - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_op == OP_TICK) begin
            idle_nxt = (idle_r == 16'hFFFF) ? idle_r : idle_r + 1'b1;
            if (idle_nxt >= cfg.idle_ack_ticks) begin
              ack_nxt = 1'b0; widx_nxt = '0; bit_nxt = '0; word_nxt = '0;
              state_nxt = S_ACK_RD;
            end
          end else if (in_seq < base_r) begin
            if (unack_r == 4'd0) unack_nxt = force_val;
            stat_nxt = ST_DUP; rel_nxt = '0; ack_nxt = 1'b0;
            state_nxt = S_STATUS;
          end else if (diff >= 32'(WINDOW)) begin
            stat_nxt = ST_BEYOND; rel_nxt = '0; ack_nxt = 1'b0;
            state_nxt = S_STATUS;
          end else begin
            seq_nxt = in_seq;
            stat_nxt = (in_seq == base_r) ? ST_IN_ORDER : ST_OUT_ORDER;
            rel_nxt = '0;
            state_nxt = S_MARK;
          end
        end
      end
      S_MARK: begin
        mem_we = 1'b1; mem_waddr = seq_r[AW-1:0]; mem_wdata = 1'b1;
        state_nxt = S_WALK_RD;
      end
      S_WALK_RD: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (mem_rdata && rel_r < RW'(WINDOW)) begin
          mem_we = 1'b1; mem_waddr = base_r[AW-1:0]; mem_wdata = 1'b0;
          base_nxt = base_r + 1'b1;
          rel_nxt = rel_r + 1'b1;
          state_nxt = S_WALK_RD;
        end else begin
          unack_nxt = (unack_r < 4'd15) ? unack_r + 1'b1 : unack_r;
          ack_nxt = (unack_nxt >= cfg.ack_every) || (seq_r > base_r);
          if (ack_nxt) unack_nxt = 4'd0;
          state_nxt = S_STATUS;
        end
      end
      S_STATUS: begin
        out_valid = 1'b1; out_last = !ack_r;
        if (ack_r) begin
          widx_nxt = '0; bit_nxt = '0; word_nxt = '0;
          state_nxt = S_ACK_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ACK_RD: begin
        mem_raddr = AW'(base_r + 32'(bpos));
        state_nxt = S_ACK_GATHER;
      end
      S_ACK_GATHER: begin
        if (32'(bpos) < 32'(NB)) begin
          word_nxt[6'd63 - bit_r[5:0]] = mem_rdata;
        end
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 7'd63) begin
          state_nxt = S_ACK_OUT;
        end else begin
          state_nxt = S_ACK_RD;
        end
      end
      S_ACK_OUT: begin
        out_valid = 1'b1; out_kind = KIND_ACK; out_status = ST_IN_ORDER;
        out_released = 9'd0; out_bitmap_word = word_r;
        out_word_index = widx_r[0];
        out_last = (widx_r == 1'(NW - 1));
        idle_nxt = 16'd0;
        if (widx_r == 1'(NW - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          widx_nxt = widx_r + 1'b1; bit_nxt = '0; word_nxt = '0;
          state_nxt = S_ACK_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; base_r <= '0; unack_r <= '0; idle_r <= '0;
      cnt_r <= '0; ack_r <= 1'b0;
    end else begin
      state_r <= state_nxt; base_r <= base_nxt; unack_r <= unack_nxt;
      idle_r <= idle_nxt; cnt_r <= cnt_nxt; ack_r <= ack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt; stat_r <= stat_nxt; rel_r <= rel_nxt;
    bit_r <= bit_nxt; widx_r <= widx_nxt; word_r <= word_nxt;
  end
endmodule
`default_nettype wire

/* rtl/selective_repeat_receive_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver window of a selective-repeat transport with ack bitmap.
//
// Input: a request is taken when start is high and busy is low; in_op
// selects data packet or millisecond tick, in_seq_number the sequence.
// Results come out one per cycle where marked by out_valid; out_last marks
// the final result of a request. The receiver cannot stall.
// The received bitmap lives in a WINDOW x 1 RAM. A data packet's status
// result follows its mark write and one RAM read per base step.
// Each 64-bit ack word is gathered with one RAM read per bit.
// Out-of-window and duplicate packets give their status in the cycle after
// acceptance. busy drops the cycle after the last result of a request.
// After reset a clearing pass sweeps every RAM address; busy stays
// high meanwhile. Configuration over the cfg_ APB port: register 0
// ack_every at 0x0, register 1 idle_ack_ticks at 0x4.
// ---------------------------------------------------------------------------
module selective_repeat_receive_window #(
  parameter int WINDOW   = srrw_pkg::WINDOW_DEF,
  parameter int ACK_BITS = srrw_pkg::ACK_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        in_op,
  input  wire logic [31:0] in_seq_number,
  output      logic        out_valid,
  output      logic        out_kind,
  output      logic [1:0]  out_status,
  output      logic [8:0]  out_released,
  output      logic [31:0] out_ack_base,
  output      logic [63:0] out_bitmap_word,
  output      logic        out_word_index,
  output      logic        out_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);
  import srrw_pkg::*;

  localparam int AW = $clog2(WINDOW);

  cfg_t          cfg;
  logic          mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;

  srrw_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  srrw_ram #(.WIDTH(1), .DEPTH(WINDOW)) u_map (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  srrw_ctrl #(.WINDOW(WINDOW), .ACK_BITS(ACK_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .start(start), .in_op(in_op),
    .in_seq(in_seq_number), .busy(busy), .mem_we(mem_we),
    .mem_waddr(mem_waddr), .mem_wdata(mem_wdata), .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata), .out_valid(out_valid), .out_kind(out_kind),
    .out_status(out_status), .out_released(out_released),
    .out_ack_base(out_ack_base), .out_bitmap_word(out_bitmap_word),
    .out_word_index(out_word_index), .out_last(out_last)
  );
endmodule
`default_nettype wire
